### rtl/ggxae_pkg.sv
// ----------------------------------------------------------------------------
// ggxae_pkg
// Shared types and constants of the GGX albedo energy compensation block:
// rational-fit coefficients, fixed-point constants and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package ggxae_pkg;

  localparam int DEFAULT_INPUT_FRAC_BITS = 15;
  localparam int COEF_W = 26;
  localparam int NUM_POLY = 4;
  localparam int NUM_MONO = 9;
  localparam int FIELD_W = 16;
  localparam int FRES_W = 3 * FIELD_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUOT_SHIFT = 15;
  localparam int QUOT_BITS = 15;
  localparam int COMP_SHIFT = 12;
  localparam int COMP_BITS = 17;
  localparam int ESS_W = 17;

  localparam logic [FIELD_W-1:0] MIN_DEN_RESET = 16'd1;
  localparam logic [FIELD_W-1:0] QUOT_ONE = 16'd32768;
  localparam logic [FIELD_W-1:0] COMP_ONE = 16'd4096;
  localparam logic [FIELD_W-1:0] COMP_MAX = 16'd65535;

  localparam logic signed [COEF_W-1:0] POLY_COEF [NUM_POLY][NUM_MONO] = '{
    '{ 26'sd6573, -26'sd41307, 26'sd638845, -26'sd133562, 26'sd1922826,
       -26'sd540344, -26'sd1732772, 26'sd1310065, -26'sd357040 },
    '{ 26'sd61243, -26'sd152240, 26'sd146080, -26'sd245629, 26'sd93323,
       -26'sd50358, 26'sd94110, 26'sd19091, 26'sd41196 },
    '{ 26'sd65536, -26'sd115671, 26'sd541524, 26'sd755630, 26'sd1897923,
       -26'sd491979, -26'sd2366505, 26'sd1039401, 26'sd2186936 },
    '{ 26'sd65536, 26'sd14949, 26'sd1044644, -26'sd3658875, 26'sd857211,
       26'sd2704015, 26'sd3597926, 26'sd19673907, -26'sd18684314 }
  };

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic int poly_width(input int frac_bits);
    return COEF_W + frac_bits + 6;
  endfunction

endpackage

`default_nettype wire

### rtl/ggx_albedo_energy_comp_top.sv
// Path: the push transfer loads the first of 6 front stages; the item then
// passes a queue write, 38 back stages and a result queue write.
// Throughput: one item per cycle while neither queue is full; pipelined
// restoring dividers, one bit per stage.
// Reset: synchronous; empties both queues, clears all valid bits and sets
// min_denominator to 1.
// ----------------------------------------------------------------------------
// ggx_albedo_energy_comp_top
// GGX directional albedo energy compensation: front polynomial pipeline,
// queue, back divider pipeline and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_albedo_energy_comp_top #(
  parameter int INPUT_FRAC_BITS = ggxae_pkg::DEFAULT_INPUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ggxae_pkg::FIELD_W-1:0] cfg_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic [ggxae_pkg::FIELD_W-1:0] view_cosine,
  input  logic [ggxae_pkg::FIELD_W-1:0] roughness_alpha,
  input  logic [ggxae_pkg::FIELD_W-1:0] fresnel_red,
  input  logic [ggxae_pkg::FIELD_W-1:0] fresnel_green,
  input  logic [ggxae_pkg::FIELD_W-1:0] fresnel_blue,
  output logic                          empty,
  input  logic                          pop,
  output logic [ggxae_pkg::FIELD_W-1:0] albedo_scale,
  output logic [ggxae_pkg::FIELD_W-1:0] albedo_bias,
  output logic [ggxae_pkg::FIELD_W-1:0] comp_red,
  output logic [ggxae_pkg::FIELD_W-1:0] comp_green,
  output logic [ggxae_pkg::FIELD_W-1:0] comp_blue
);
  import ggxae_pkg::*;

  localparam int PW    = poly_width(INPUT_FRAC_BITS);
  localparam int MID_W = NUM_POLY * PW + FRES_W;
  localparam int OUT_W = 5 * FIELD_W;

  logic [FIELD_W-1:0] min_den;
  logic [FIELD_W-1:0] floor_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_den <= MIN_DEN_RESET;
    end else if (cfg_we) begin
      min_den <= cfg_wdata;
    end
  end

  assign floor_val = (min_den == '0) ? MIN_DEN_RESET : min_den;

  fifo_status_t mid_st, out_st;
  logic front_en, back_en;
  logic front_v, back_v;
  logic [NUM_POLY*PW-1:0] front_r;
  logic [FRES_W-1:0]      front_fres;
  logic [MID_W-1:0]       mid_q;
  logic [FIELD_W-1:0]     b_scale, b_bias, b_red, b_green, b_blue;
  logic [OUT_W-1:0]       out_q;

  assign front_en = !mid_st.full;
  assign back_en  = !out_st.full;
  assign full     = mid_st.full;

  ggxae_front #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(front_en), .in_valid(push && !full),
    .view_cosine(view_cosine), .roughness_alpha(roughness_alpha),
    .in_fres({fresnel_blue, fresnel_green, fresnel_red}),
    .out_valid(front_v), .out_r(front_r), .out_fres(front_fres)
  );

  ggxae_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .wr(front_en && front_v), .wdata({front_r, front_fres}),
    .rd(back_en && !mid_st.empty), .rdata(mid_q), .status(mid_st)
  );

  ggxae_back #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(back_en), .in_valid(!mid_st.empty),
    .in_r(mid_q[MID_W-1 -: NUM_POLY*PW]), .in_fres(mid_q[FRES_W-1:0]),
    .floor_val(floor_val), .out_valid(back_v),
    .albedo_scale(b_scale), .albedo_bias(b_bias),
    .comp_red(b_red), .comp_green(b_green), .comp_blue(b_blue)
  );

  ggxae_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .wr(back_en && back_v),
    .wdata({b_scale, b_bias, b_red, b_green, b_blue}),
    .rd(pop && !out_st.empty), .rdata(out_q), .status(out_st)
  );

  assign empty = out_st.empty;
  assign {albedo_scale, albedo_bias, comp_red, comp_green, comp_blue} = out_q;

endmodule

`default_nettype wire

### rtl/ggxae_fifo.sv
// ----------------------------------------------------------------------------
// ggxae_fifo
// Short first-in first-out queue with a show-ahead output.
// ----------------------------------------------------------------------------
`default_nettype none

module ggxae_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ggxae_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    rd,
  output logic [WIDTH-1:0]        rdata,
  output ggxae_pkg::fifo_status_t status
);
  import ggxae_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assign rdata        = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (AW+1)'(DEPTH));

endmodule

`default_nettype wire

### rtl/ggxae_front.sv
// ----------------------------------------------------------------------------
// ggxae_front
// Front pipeline: saturate inputs, build monomials and sum the four
// rational-fit polynomials.
// ----------------------------------------------------------------------------
`default_nettype none

module ggxae_front #(
  parameter int INPUT_FRAC_BITS = ggxae_pkg::DEFAULT_INPUT_FRAC_BITS
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  logic                                                    in_valid,
  input  logic [ggxae_pkg::FIELD_W-1:0]                           view_cosine,
  input  logic [ggxae_pkg::FIELD_W-1:0]                           roughness_alpha,
  input  logic [ggxae_pkg::FRES_W-1:0]                            in_fres,
  output logic                                                    out_valid,
  output logic [ggxae_pkg::NUM_POLY*ggxae_pkg::poly_width(INPUT_FRAC_BITS)-1:0] out_r,
  output logic [ggxae_pkg::FRES_W-1:0]                            out_fres
);
  import ggxae_pkg::*;

  localparam int F    = INPUT_FRAC_BITS;
  localparam int XW   = F + 1;
  localparam int SATW = (F + 1 > FIELD_W) ? F + 1 : FIELD_W;
  localparam int PRW  = COEF_W + XW + 1;
  localparam int PW   = poly_width(F);
  localparam logic [SATW-1:0] ONE_S = SATW'(1) << F;
  localparam logic [XW-1:0]   ONE_X = XW'(1) << F;
  localparam logic [2*XW-1:0] HALF  = (2*XW)'(1) << (F - 1);

  function automatic logic [XW-1:0] sat_one(input logic [FIELD_W-1:0] v);
    logic [SATW-1:0] w;
    w = SATW'(v);
    return (w > ONE_S) ? ONE_X : XW'(w);
  endfunction

  function automatic logic [XW-1:0] fmul(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [2*XW-1:0] p;
    p = (2*XW)'(a) * (2*XW)'(b) + HALF;
    return p[F +: XW];
  endfunction

  logic [5:0] v;

  logic [XW-1:0] x0, y0;
  logic [XW-1:0] x1, y1, m3_1, m4_1, m5_1;
  logic [XW-1:0] mono [NUM_MONO];
  logic signed [PRW-1:0] prod [NUM_POLY][NUM_MONO];
  logic signed [PW-1:0]  part [NUM_POLY][3];
  logic signed [PW-1:0]  r5 [NUM_POLY];
  logic [FRES_W-1:0] fr [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= sat_one(view_cosine);
      y0    <= sat_one(roughness_alpha);
      fr[0] <= in_fres;
      for (int s = 1; s < 6; s++) begin
        fr[s] <= fr[s-1];
      end
      x1   <= x0;
      y1   <= y0;
      m3_1 <= fmul(x0, y0);
      m4_1 <= fmul(x0, x0);
      m5_1 <= fmul(y0, y0);
      mono[0] <= ONE_X;
      mono[1] <= x1;
      mono[2] <= y1;
      mono[3] <= m3_1;
      mono[4] <= m4_1;
      mono[5] <= m5_1;
      mono[6] <= fmul(m4_1, y1);
      mono[7] <= fmul(x1, m5_1);
      mono[8] <= fmul(m4_1, m5_1);
      for (int p = 0; p < NUM_POLY; p++) begin
        for (int k = 0; k < NUM_MONO; k++) begin
          prod[p][k] <= PRW'(POLY_COEF[p][k]) * $signed({1'b0, mono[k]});
        end
        for (int j = 0; j < 3; j++) begin
          part[p][j] <= PW'(prod[p][3*j]) + PW'(prod[p][3*j+1]) + PW'(prod[p][3*j+2]);
        end
        r5[p] <= part[p][0] + part[p][1] + part[p][2];
      end
    end
  end

  assign out_valid = v[5];
  assign out_r     = {r5[3], r5[2], r5[1], r5[0]};
  assign out_fres  = fr[5];

endmodule

`default_nettype wire

### rtl/ggxae_div.sv
// ----------------------------------------------------------------------------
// ggxae_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit the quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ggxae_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QB = 4,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QB-1:0] q,
  output logic          ovf,
  output logic [TW-1:0] out_tag
);
  import ggxae_pkg::*;

  localparam int SW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [QB:0]     v;
  logic [SW-1:0]   rem [QB];
  logic [DW-1:0]   dv  [QB];
  logic [QB-1:0]   qa  [QB+1];
  logic            of  [QB+1];
  logic [TW-1:0]   tg  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= SW'(n);
      dv[0]  <= d;
      qa[0]  <= '0;
      of[0]  <= SW'(n) >= (SW'(d) << QB);
      tg[0]  <= in_tag;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [SW-1:0] shd;
    logic          take;

    assign shd  = SW'(dv[i-1]) << (QB - i);
    assign take = rem[i-1] >= shd;

    always_ff @(posedge clk) begin
      if (en) begin
        qa[i] <= qa[i-1] | (take ? (QB'(1) << (QB - i)) : '0);
        of[i] <= of[i-1];
        tg[i] <= tg[i-1];
      end
    end

    if (i < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? rem[i-1] - shd : rem[i-1];
          dv[i]  <= dv[i-1];
        end
      end
    end
  end

  assign out_valid = v[QB];
  assign q         = qa[QB];
  assign ovf       = of[QB];
  assign out_tag   = tg[QB];

endmodule

`default_nettype wire

### rtl/ggxae_back.sv
// ----------------------------------------------------------------------------
// ggxae_back
// Back pipeline: clamped quotients A and B, Ess and the three
// compensation factors.
// ----------------------------------------------------------------------------
`default_nettype none

module ggxae_back #(
  parameter int INPUT_FRAC_BITS = ggxae_pkg::DEFAULT_INPUT_FRAC_BITS
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  logic                                                    in_valid,
  input  logic [ggxae_pkg::NUM_POLY*ggxae_pkg::poly_width(INPUT_FRAC_BITS)-1:0] in_r,
  input  logic [ggxae_pkg::FRES_W-1:0]                            in_fres,
  input  logic [ggxae_pkg::FIELD_W-1:0]                           floor_val,
  output logic                                                    out_valid,
  output logic [ggxae_pkg::FIELD_W-1:0]                           albedo_scale,
  output logic [ggxae_pkg::FIELD_W-1:0]                           albedo_bias,
  output logic [ggxae_pkg::FIELD_W-1:0]                           comp_red,
  output logic [ggxae_pkg::FIELD_W-1:0]                           comp_green,
  output logic [ggxae_pkg::FIELD_W-1:0]                           comp_blue
);
  import ggxae_pkg::*;

  localparam int F    = INPUT_FRAC_BITS;
  localparam int XW   = F + 1;
  localparam int SATW = (F + 1 > FIELD_W) ? F + 1 : FIELD_W;
  localparam int PW   = poly_width(F);
  localparam int NWQ  = PW + QUOT_SHIFT;
  localparam int NWC  = XW + FIELD_W + COMP_SHIFT;
  localparam int DWC  = ESS_W + F;
  localparam int TGC  = 2 * FIELD_W + 1;
  localparam logic [SATW-1:0] ONE_S = SATW'(1) << F;
  localparam logic [XW-1:0]   ONE_X = XW'(1) << F;

  function automatic logic [XW-1:0] sat_one(input logic [FIELD_W-1:0] w16);
    logic [SATW-1:0] w;
    w = SATW'(w16);
    return (w > ONE_S) ? ONE_X : XW'(w);
  endfunction

  function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] s);
    return s[PW-1] ? PW'(-s) : PW'(s);
  endfunction

  function automatic logic [FIELD_W-1:0] quot(input logic kill, input logic of,
                                              input logic [QUOT_BITS-1:0] qv);
    logic [FIELD_W-1:0] res;
    if (kill) begin
      res = '0;
    end else if (of) begin
      res = QUOT_ONE;
    end else begin
      res = FIELD_W'(qv);
    end
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] comp(input logic neg, input logic of,
                                              input logic [COMP_BITS-1:0] term);
    logic [COMP_BITS:0] sum;
    logic [FIELD_W-1:0] res;
    sum = (COMP_BITS+1)'(COMP_ONE) + (COMP_BITS+1)'(term);
    if (of) begin
      res = neg ? '0 : COMP_MAX;
    end else if (neg) begin
      res = (term > COMP_BITS'(COMP_ONE)) ? '0 : FIELD_W'(COMP_BITS'(COMP_ONE) - term);
    end else begin
      res = (sum > (COMP_BITS+1)'(COMP_MAX)) ? COMP_MAX : FIELD_W'(sum);
    end
    return res;
  endfunction

  // quotient setup
  logic [PW-1:0] eps, dma_c, dmb_c, nma_c, nmb_c;
  logic          ka_c, kb_c;
  logic signed [PW-1:0] num_a, num_b, den_a, den_b;

  always_comb begin
    num_a = in_r[0*PW +: PW];
    num_b = in_r[1*PW +: PW];
    den_a = in_r[2*PW +: PW];
    den_b = in_r[3*PW +: PW];
    eps   = PW'(floor_val) << (F + 1);
    dma_c = mag(den_a);
    dmb_c = mag(den_b);
    nma_c = mag(num_a);
    nmb_c = mag(num_b);
    if (dma_c < eps) begin
      dma_c = eps;
    end
    if (dmb_c < eps) begin
      dmb_c = eps;
    end
    ka_c = (nma_c == '0) || (num_a[PW-1] != den_a[PW-1]);
    kb_c = (nmb_c == '0) || (num_b[PW-1] != den_b[PW-1]);
  end

  logic              v0;
  logic [NWQ-1:0]    na0, nb0;
  logic [PW-1:0]     da0, db0;
  logic              ka0, kb0;
  logic [FRES_W-1:0] fr0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na0 <= {nma_c, {QUOT_SHIFT{1'b0}}};
      nb0 <= {nmb_c, {QUOT_SHIFT{1'b0}}};
      da0 <= dma_c;
      db0 <= dmb_c;
      ka0 <= ka_c;
      kb0 <= kb_c;
      fr0 <= in_fres;
    end
  end

  logic                 va_q, vb_q, ofa, ofb, ka_q, kb_q;
  logic [QUOT_BITS-1:0] qa, qb;
  logic [FRES_W-1:0]    fr_q;

  ggxae_div #(.NW(NWQ), .DW(PW), .QB(QUOT_BITS), .TW(1)) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .n(na0), .d(da0), .in_tag(ka0),
    .out_valid(va_q), .q(qa), .ovf(ofa), .out_tag(ka_q)
  );

  ggxae_div #(.NW(NWQ), .DW(PW), .QB(QUOT_BITS), .TW(FRES_W + 1)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .n(nb0), .d(db0),
    .in_tag({kb0, fr0}),
    .out_valid(vb_q), .q(qb), .ovf(ofb), .out_tag({kb_q, fr_q})
  );

  // Ess
  logic               v1;
  logic [FIELD_W-1:0] a1, b1;
  logic [ESS_W-1:0]   ess1;
  logic [ESS_W-1:0]   ess_c;
  logic [FIELD_W-1:0] a_c, b_c;
  logic [FRES_W-1:0]  fr1;

  always_comb begin
    a_c   = quot(ka_q, ofa, qa);
    b_c   = quot(kb_q, ofb, qb);
    ess_c = ESS_W'(a_c) + ESS_W'(b_c);
    if (ess_c < ESS_W'(floor_val)) begin
      ess_c = ESS_W'(floor_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= va_q & vb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a_c;
      b1   <= b_c;
      ess1 <= ess_c;
      fr1  <= fr_q;
    end
  end

  // numerators of the compensation quotients
  logic                    v2, neg2;
  logic [FIELD_W-1:0]      a2, b2;
  logic [ESS_W-1:0]        ess2;
  logic [XW+FIELD_W-1:0]   prod2 [3];
  logic                    neg_c;
  logic [FIELD_W-1:0]      dm_c;

  always_comb begin
    neg_c = ess1 > ESS_W'(QUOT_ONE);
    dm_c  = neg_c ? FIELD_W'(ess1 - ESS_W'(QUOT_ONE)) : FIELD_W'(ESS_W'(QUOT_ONE) - ess1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg_c;
      a2   <= a1;
      b2   <= b1;
      ess2 <= ess1;
      for (int c = 0; c < 3; c++) begin
        prod2[c] <= (XW+FIELD_W)'(sat_one(fr1[c*FIELD_W +: FIELD_W])) *
                    (XW+FIELD_W)'(dm_c);
      end
    end
  end

  logic [DWC-1:0] dc;
  assign dc = {ess2, {F{1'b0}}};

  logic                 vc0, vc1, vc2, ofc0, ofc1, ofc2, negc1, negc2;
  logic [COMP_BITS-1:0] tc0, tc1, tc2;
  logic [TGC-1:0]       tag0;

  ggxae_div #(.NW(NWC), .DW(DWC), .QB(COMP_BITS), .TW(TGC)) u_div_r (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .n({prod2[0], {COMP_SHIFT{1'b0}}}),
    .d(dc), .in_tag({a2, b2, neg2}),
    .out_valid(vc0), .q(tc0), .ovf(ofc0), .out_tag(tag0)
  );

  ggxae_div #(.NW(NWC), .DW(DWC), .QB(COMP_BITS), .TW(1)) u_div_g (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .n({prod2[1], {COMP_SHIFT{1'b0}}}),
    .d(dc), .in_tag(neg2),
    .out_valid(vc1), .q(tc1), .ovf(ofc1), .out_tag(negc1)
  );

  ggxae_div #(.NW(NWC), .DW(DWC), .QB(COMP_BITS), .TW(1)) u_div_b2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .n({prod2[2], {COMP_SHIFT{1'b0}}}),
    .d(dc), .in_tag(neg2),
    .out_valid(vc2), .q(tc2), .ovf(ofc2), .out_tag(negc2)
  );

  logic v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vc0 & vc1 & vc2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      albedo_scale <= tag0[TGC-1 -: FIELD_W];
      albedo_bias  <= tag0[FIELD_W:1];
      comp_red     <= comp(tag0[0], ofc0, tc0);
      comp_green   <= comp(negc1, ofc1, tc1);
      comp_blue    <= comp(negc2, ofc2, tc2);
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

### rtl/ggxae_chk.sv
// ----------------------------------------------------------------------------
// ggxae_chk
// Port-level checks of the GGX albedo energy compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

module ggxae_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          push,
  input logic                          full,
  input logic                          pop,
  input logic                          empty,
  input logic [ggxae_pkg::FIELD_W-1:0] albedo_scale,
  input logic [ggxae_pkg::FIELD_W-1:0] albedo_bias
);
  import ggxae_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> albedo_scale <= QUOT_ONE)
    else $error("albedo_scale above one");

  a_bias_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> albedo_bias <= QUOT_ONE)
    else $error("albedo_bias above one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(albedo_scale) && $stable(albedo_bias))
    else $error("waiting result changed before transfer");

endmodule

bind ggx_albedo_energy_comp_top ggxae_chk u_chk (.*);

`default_nettype wire

### verif/tb_ggx_albedo_energy_comp_top.sv
// ----------------------------------------------------------------------------
// tb_ggx_albedo_energy_comp_top
// Streams view cosine, roughness and Fresnel items through the energy
// compensation block under random push and pop gaps. Each transfer is checked
// field by field against an in-bench fixed-point model of the rational fit,
// across several min_denominator settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ggx_albedo_energy_comp_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ggxae_pkg::*;

  localparam int FRAC = 15;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t cosv;
    word_t alpha;
    word_t fr;
    word_t fg;
    word_t fb;
  } shade_in_t;

  typedef struct packed {
    word_t scale;
    word_t bias;
    word_t cr;
    word_t cg;
    word_t cb;
  } shade_out_t;

  typedef struct packed {
    shade_in_t  item;
    logic       comp_known;
    word_t      comp_val;
  } vector_t;

  localparam longint FIT [4][9] = '{
    '{ 6573, -41307, 638845, -133562, 1922826, -540344, -1732772, 1310065, -357040 },
    '{ 61243, -152240, 146080, -245629, 93323, -50358, 94110, 19091, 41196 },
    '{ 65536, -115671, 541524, 755630, 1897923, -491979, -2366505, 1039401, 2186936 },
    '{ 65536, 14949, 1044644, -3658875, 857211, 2704015, 3597926, 19673907, -18684314 }
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_we = 1'b0;
  word_t cfg_wdata = '0;
  logic  push = 1'b0;
  logic  full;
  word_t view_cosine = '0, roughness_alpha = '0;
  word_t fresnel_red = '0, fresnel_green = '0, fresnel_blue = '0;
  logic  empty;
  logic  pop = 1'b0;
  word_t albedo_scale, albedo_bias, comp_red, comp_green, comp_blue;

  word_t      floor_setting = MIN_DEN_RESET;
  shade_out_t pending_q[$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         row_idx = 0;
  logic       steady = 1'b0;

  always #1 clk = ~clk;

  ggx_albedo_energy_comp_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full),
    .view_cosine(view_cosine), .roughness_alpha(roughness_alpha),
    .fresnel_red(fresnel_red), .fresnel_green(fresnel_green),
    .fresnel_blue(fresnel_blue),
    .empty(empty), .pop(pop),
    .albedo_scale(albedo_scale), .albedo_bias(albedo_bias),
    .comp_red(comp_red), .comp_green(comp_green), .comp_blue(comp_blue)
  );

  function automatic longint unsigned clamp_one(word_t v);
    return (v > 16'd32768) ? 64'd32768 : 64'(v);
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  function automatic longint unsigned fit_ratio(longint num, longint den, word_t fl);
    longint unsigned eps, dm, nm, q;
    eps = 64'(fl) << (FRAC + 1);
    dm = (den < 0) ? 64'(-den) : 64'(den);
    nm = (num < 0) ? 64'(-num) : 64'(num);
    if (dm < eps) dm = eps;
    if (nm == 0 || ((num < 0) != (den < 0))) return 0;
    q = (nm << 15) / dm;
    return (q > 32768) ? 64'd32768 : q;
  endfunction

  function automatic word_t comp_factor(longint unsigned f, longint unsigned ess);
    longint diff, res;
    longint unsigned dm, term;
    diff = 32768 - longint'(ess);
    dm = (diff < 0) ? 64'(-diff) : 64'(diff);
    term = (f * dm * 4096) / (ess << FRAC);
    res = (diff < 0) ? 4096 - longint'(term) : 4096 + longint'(term);
    if (res < 0) res = 0;
    if (res > 65535) res = 65535;
    return word_t'(res);
  endfunction

  function automatic shade_out_t energy_comp(shade_in_t it, word_t reg_floor);
    longint unsigned x, y, a, b, ess;
    longint unsigned mono [9];
    longint r [4];
    word_t fl;
    shade_out_t o;
    fl = (reg_floor == 0) ? 16'd1 : reg_floor;
    x = clamp_one(it.cosv);
    y = clamp_one(it.alpha);
    mono[0] = 64'd1 << FRAC;
    mono[1] = x;
    mono[2] = y;
    mono[3] = qmul(x, y);
    mono[4] = qmul(x, x);
    mono[5] = qmul(y, y);
    mono[6] = qmul(mono[4], y);
    mono[7] = qmul(x, mono[5]);
    mono[8] = qmul(mono[4], mono[5]);
    for (int p = 0; p < 4; p++) begin
      r[p] = 0;
      for (int k = 0; k < 9; k++) r[p] += FIT[p][k] * longint'(mono[k]);
    end
    a = fit_ratio(r[0], r[2], fl);
    b = fit_ratio(r[1], r[3], fl);
    ess = a + b;
    if (ess < fl) ess = fl;
    o.scale = word_t'(a);
    o.bias = word_t'(b);
    o.cr = comp_factor(clamp_one(it.fr), ess);
    o.cg = comp_factor(clamp_one(it.fg), ess);
    o.cb = comp_factor(clamp_one(it.fb), ess);
    return o;
  endfunction

  task automatic report(string field, word_t got, word_t want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  function automatic word_t rand_field();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 16'd0;
    if (sel < 16) return 16'd32768;
    if (sel < 26) return word_t'($urandom_range(65535));
    return word_t'($urandom_range(32768));
  endfunction

  vector_t directed [] = '{
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, 16'd4096},
    '{'{16'd32768, 16'd32768, 16'd0, 16'd0, 16'd0}, 1'b1, 16'd4096},
    '{'{16'd0, 16'd32768, 16'd0, 16'd0, 16'd0}, 1'b1, 16'd4096},
    '{'{16'd32768, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, 16'd4096},
    '{'{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0}, 1'b1, 16'd4096},
    '{'{16'd0, 16'd0, 16'd32768, 16'd32768, 16'd32768}, 1'b0, 16'd0},
    '{'{16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768}, 1'b0, 16'd0},
    '{'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b0, 16'd0},
    '{'{16'd32769, 16'd40000, 16'd50000, 16'd32769, 16'd65534}, 1'b0, 16'd0},
    '{'{16'd1, 16'd1, 16'd1, 16'd1, 16'd1}, 1'b0, 16'd0},
    '{'{16'd16384, 16'd16384, 16'd16384, 16'd8192, 16'd24576}, 1'b0, 16'd0},
    '{'{16'd32768, 16'd1024, 16'd21845, 16'd10923, 16'd32767}, 1'b0, 16'd0},
    '{'{16'd1024, 16'd32768, 16'd32767, 16'd100, 16'd5000}, 1'b0, 16'd0},
    '{'{16'd30000, 16'd3000, 16'd32768, 16'd0, 16'd16384}, 1'b0, 16'd0},
    '{'{16'd3000, 16'd30000, 16'd0, 16'd32768, 16'd16384}, 1'b0, 16'd0},
    '{'{16'h5555, 16'h2AAA, 16'hAAAA, 16'h5555, 16'h7FFF}, 1'b0, 16'd0}
  };

  word_t floor_plan [5] = '{16'd0, 16'd65535, 16'd0, 16'd300, 16'd1};

  always @(posedge clk) begin
    shade_out_t want;
    if (!rst) begin
      if (cfg_we) floor_setting = cfg_wdata;
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (push && !full) begin
        pending_q.push_back(energy_comp({view_cosine, roughness_alpha, fresnel_red,
                                         fresnel_green, fresnel_blue}, floor_setting));
        // Typed compensation rows: zero Fresnel leaves every channel at unity.
        if (row_idx < directed.size()) begin
          if (directed[row_idx].comp_known) begin
            pending_q[pending_q.size() - 1].cr = directed[row_idx].comp_val;
            pending_q[pending_q.size() - 1].cg = directed[row_idx].comp_val;
            pending_q[pending_q.size() - 1].cb = directed[row_idx].comp_val;
          end
          row_idx++;
        end
      end
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          report("unexpected transfer", albedo_scale, '0);
        end else begin
          want = pending_q.pop_front();
          if (albedo_scale !== want.scale) report("albedo_scale", albedo_scale, want.scale);
          if (albedo_bias !== want.bias) report("albedo_bias", albedo_bias, want.bias);
          if (comp_red !== want.cr) report("comp_red", comp_red, want.cr);
          if (comp_green !== want.cg) report("comp_green", comp_green, want.cg);
          if (comp_blue !== want.cb) report("comp_blue", comp_blue, want.cb);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 29);
  end

  task automatic send(shade_in_t it);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    {view_cosine, roughness_alpha, fresnel_red, fresnel_green, fresnel_blue} <= it;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_and_write(word_t v);
    push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    shade_in_t it;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send(directed[i].item);
    end
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) drain_and_write((ph == 3) ? word_t'($urandom_range(1, 65535))
                                            : floor_plan[ph - 1]);
      for (int n = 0; n < 105; n++) begin
        steady <= (ph == 2 && n >= 20 && n < 80);
        it = '{rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
        send(it);
      end
    end
    steady <= 1'b0;
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && !empty) error_count++;
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### ggx_albedo_energy_comp_top.f
rtl/ggxae_pkg.sv
rtl/ggxae_fifo.sv
rtl/ggxae_front.sv
rtl/ggxae_div.sv
rtl/ggxae_back.sv
rtl/ggx_albedo_energy_comp_top.sv
rtl/ggxae_chk.sv
verif/tb_ggx_albedo_energy_comp_top.sv
